/* sv/segment_intersection_defines.svh */
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Implication checked outside reset.
`define SI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment_intersection: check failed");

// Property checked at every edge, reset included.
`define SI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("segment_intersection: check failed");

`endif

/* sv/si_pkg.sv */
package si_pkg;

  // signed width of the determinant and the t and u numerators
  function automatic int det_w(input int cb);
    return 2 * cb + 3;
  endfunction

  // width of the quotient, which never exceeds the coordinate span
  function automatic int quo_w(input int cb);
    return cb + 1;
  endfunction

  // width of the dividend tn * |e|
  function automatic int num_w(input int cb);
    return det_w(cb) + quo_w(cb);
  endfunction

endpackage

/* sv/segment_intersection.sv */
// Segment intersection: one request per cycle, fully pipelined.
// Stages: 4 front stages (differences, products, sign fold, dividend),
// then COORD_BITS+1 divider cells, then the output register.
// Throughput: one request per cycle; the whole pipe holds while a result waits
// in the output register with m_tready low.
// Reset (rst, synchronous) clears the valid bits only; no other state.
`include "segment_intersection_defines.svh"
module segment_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // px, py
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // hit
  output logic [0:0] m_tuser
);
  import si_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = det_w(CB);
  localparam int QB  = quo_w(CB);
  localparam int NW  = num_w(CB);
  localparam int OW  = ((2*COORD_BITS+7)/8)*8;
  // the scale cancels in t; the fraction width only bounds the format
  localparam int FB  = (FRAC_BITS < CB) ? FRAC_BITS : CB - 1;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic              c_valid [QB+1];
  logic              c_hit   [QB+1];
  logic [DW-1:0]     c_d     [QB+1];
  logic [NW-1:0]     c_rx    [QB+1];
  logic [NW-1:0]     c_ry    [QB+1];
  logic [QB-1:0]     c_qx    [QB+1];
  logic [QB-1:0]     c_qy    [QB+1];
  logic              c_negx  [QB+1];
  logic              c_negy  [QB+1];
  logic signed [CB-1:0] c_ax [QB+1];
  logic signed [CB-1:0] c_ay [QB+1];

  si_front #(.CB(CB)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && en),
    .ax(s_tdata[0*CB +: CB]), .ay(s_tdata[1*CB +: CB]),
    .bx(s_tdata[2*CB +: CB]), .by_coord(s_tdata[3*CB +: CB]),
    .cx(s_tdata[4*CB +: CB]), .cy(s_tdata[5*CB +: CB]),
    .dx(s_tdata[6*CB +: CB]), .dy(s_tdata[7*CB +: CB]),
    .out_valid(c_valid[0]), .out_hit(c_hit[0]), .out_d(c_d[0]),
    .out_nx(c_rx[0]), .out_ny(c_ry[0]),
    .out_negx(c_negx[0]), .out_negy(c_negy[0]),
    .out_ax(c_ax[0]), .out_ay(c_ay[0])
  );

  assign c_qx[0] = '0;
  assign c_qy[0] = '0;

  // cell k settles quotient bit QB-1-k
  for (genvar k = 0; k < QB; k++) begin : g_cell
    si_div_cell #(.CB(CB), .STEP(QB-1-k)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(c_valid[k]), .in_hit(c_hit[k]), .in_d(c_d[k]),
      .in_rx(c_rx[k]), .in_ry(c_ry[k]), .in_qx(c_qx[k]), .in_qy(c_qy[k]),
      .in_negx(c_negx[k]), .in_negy(c_negy[k]),
      .in_ax(c_ax[k]), .in_ay(c_ay[k]),
      .out_valid(c_valid[k+1]), .out_hit(c_hit[k+1]), .out_d(c_d[k+1]),
      .out_rx(c_rx[k+1]), .out_ry(c_ry[k+1]), .out_qx(c_qx[k+1]),
      .out_qy(c_qy[k+1]), .out_negx(c_negx[k+1]), .out_negy(c_negy[k+1]),
      .out_ax(c_ax[k+1]), .out_ay(c_ay[k+1])
    );
  end

  logic [QB-1:0] sqx, sqy;
  logic [CB-1:0] px_c, py_c;
  logic [FB:0]   unused_frac;

  always_comb begin
    sqx  = c_negx[QB] ? -c_qx[QB] : c_qx[QB];
    sqy  = c_negy[QB] ? -c_qy[QB] : c_qy[QB];
    px_c = $unsigned(c_ax[QB]) + sqx[CB-1:0];
    py_c = $unsigned(c_ay[QB]) + sqy[CB-1:0];
    unused_frac = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= c_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[0] <= c_hit[QB];
      m_tdata    <= c_hit[QB] ? OW'({py_c, px_c}) : OW'(unused_frac) & '0;
    end
  end

  `SI_ASSERT_IMPL(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
  `SI_ASSERT_IMPL(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))
  `SI_ASSERT_IMPL(a_reset_clears, $past(rst), !m_tvalid)

endmodule

/* sv/si_front.sv */
module si_front #(
  parameter int CB = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [CB-1:0]                   ax,
  input  logic signed [CB-1:0]                   ay,
  input  logic signed [CB-1:0]                   bx,
  input  logic signed [CB-1:0]                   by_coord,
  input  logic signed [CB-1:0]                   cx,
  input  logic signed [CB-1:0]                   cy,
  input  logic signed [CB-1:0]                   dx,
  input  logic signed [CB-1:0]                   dy,
  output logic                                   out_valid,
  output logic                                   out_hit,
  output logic [si_pkg::det_w(CB)-1:0]           out_d,
  output logic [si_pkg::num_w(CB)-1:0]           out_nx,
  output logic [si_pkg::num_w(CB)-1:0]           out_ny,
  output logic                                   out_negx,
  output logic                                   out_negy,
  output logic signed [CB-1:0]                   out_ax,
  output logic signed [CB-1:0]                   out_ay
);
  import si_pkg::*;

  localparam int DW = det_w(CB);
  localparam int QB = quo_w(CB);
  localparam int NW = num_w(CB);
  localparam int PW = 2 * CB + 2;

  // stage 1: differences
  logic              v1;
  logic signed [CB:0] d12x, d12y, d34x, d34y, d13x, d13y, ex1, ey1;
  logic signed [CB-1:0] ax1, ay1;
  // stage 2: products
  logic              v2;
  logic signed [PW-1:0] pd0, pd1, pt0, pt1, pu0, pu1;
  logic signed [CB:0] ex2, ey2;
  logic signed [CB-1:0] ax2, ay2;
  // stage 3: sign fold and range test
  logic              v3, hit3, negx3, negy3;
  logic [DW-1:0]     dm3, tnm3;
  logic [QB-1:0]     exm3, eym3;
  logic signed [CB-1:0] ax3, ay3;

  logic signed [DW-1:0] d_c, tn_c, un_c, dm_c, tnm_c, unm_c;
  logic                 hit_c;

  always_comb begin
    d_c  = DW'(pd0) - DW'(pd1);
    tn_c = DW'(pt0) - DW'(pt1);
    un_c = DW'(pu0) - DW'(pu1);
    dm_c  = d_c[DW-1] ? -d_c  : d_c;
    tnm_c = d_c[DW-1] ? -tn_c : tn_c;
    unm_c = d_c[DW-1] ? -un_c : un_c;
    hit_c = (d_c != '0) && !tnm_c[DW-1] && !unm_c[DW-1]
            && ($unsigned(tnm_c) <= $unsigned(dm_c))
            && ($unsigned(unm_c) <= $unsigned(dm_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d12x <= (CB+1)'(ax) - (CB+1)'(bx);
      d12y <= (CB+1)'(ay) - (CB+1)'(by_coord);
      d34x <= (CB+1)'(cx) - (CB+1)'(dx);
      d34y <= (CB+1)'(cy) - (CB+1)'(dy);
      d13x <= (CB+1)'(ax) - (CB+1)'(cx);
      d13y <= (CB+1)'(ay) - (CB+1)'(cy);
      ex1  <= (CB+1)'(bx) - (CB+1)'(ax);
      ey1  <= (CB+1)'(by_coord) - (CB+1)'(ay);
      ax1  <= ax;
      ay1  <= ay;

      pd0 <= d12x * d34y;
      pd1 <= d12y * d34x;
      pt0 <= d13x * d34y;
      pt1 <= d13y * d34x;
      pu0 <= d13x * d12y;
      pu1 <= d13y * d12x;
      ex2 <= ex1;
      ey2 <= ey1;
      ax2 <= ax1;
      ay2 <= ay1;

      hit3  <= hit_c;
      dm3   <= $unsigned(dm_c);
      tnm3  <= $unsigned(tnm_c);
      negx3 <= ex2[CB];
      negy3 <= ey2[CB];
      exm3  <= ex2[CB] ? $unsigned(-ex2) : $unsigned(ex2);
      eym3  <= ey2[CB] ? $unsigned(-ey2) : $unsigned(ey2);
      ax3   <= ax2;
      ay3   <= ay2;

      // dividend tn * |e|, one multiplier per lane
      out_hit  <= hit3;
      out_d    <= dm3;
      out_nx   <= NW'(tnm3) * NW'(exm3);
      out_ny   <= NW'(tnm3) * NW'(eym3);
      out_negx <= negx3;
      out_negy <= negy3;
      out_ax   <= ax3;
      out_ay   <= ay3;
    end
  end

endmodule

/* sv/si_div_cell.sv */
module si_div_cell #(
  parameter int CB   = 16,
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic                             in_hit,
  input  logic [si_pkg::det_w(CB)-1:0]     in_d,
  input  logic [si_pkg::num_w(CB)-1:0]     in_rx,
  input  logic [si_pkg::num_w(CB)-1:0]     in_ry,
  input  logic [si_pkg::quo_w(CB)-1:0]     in_qx,
  input  logic [si_pkg::quo_w(CB)-1:0]     in_qy,
  input  logic                             in_negx,
  input  logic                             in_negy,
  input  logic signed [CB-1:0]             in_ax,
  input  logic signed [CB-1:0]             in_ay,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [si_pkg::det_w(CB)-1:0]     out_d,
  output logic [si_pkg::num_w(CB)-1:0]     out_rx,
  output logic [si_pkg::num_w(CB)-1:0]     out_ry,
  output logic [si_pkg::quo_w(CB)-1:0]     out_qx,
  output logic [si_pkg::quo_w(CB)-1:0]     out_qy,
  output logic                             out_negx,
  output logic                             out_negy,
  output logic signed [CB-1:0]             out_ax,
  output logic signed [CB-1:0]             out_ay
);
  import si_pkg::*;

  localparam int NW = num_w(CB);
  localparam int QB = quo_w(CB);

  logic [NW-1:0] dsh;
  logic          gex, gey;

  // one restoring step per lane against the divisor shifted to this bit
  always_comb begin
    dsh = NW'(in_d) << STEP;
    gex = in_rx >= dsh;
    gey = in_ry >= dsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit  <= in_hit;
      out_d    <= in_d;
      out_rx   <= gex ? in_rx - dsh : in_rx;
      out_ry   <= gey ? in_ry - dsh : in_ry;
      out_qx   <= in_qx | (QB'(gex) << STEP);
      out_qy   <= in_qy | (QB'(gey) << STEP);
      out_negx <= in_negx;
      out_negy <= in_negy;
      out_ax   <= in_ax;
      out_ay   <= in_ay;
    end
  end

endmodule
